// File: rtl/dlii_pkg.sv
// ----------------------------------------------------------------------------
// dlii_pkg
// Shared types, constants and helpers of the display list index inserter.
// ----------------------------------------------------------------------------
package dlii_pkg;

    // Rewritten list is padded with zeros to a multiple of this many bytes.
    localparam int ALIGN_BYTES = 32;
    localparam int MOD_W       = (ALIGN_BYTES > 1) ? $clog2(ALIGN_BYTES) : 1;
    // Largest number of results for one request: two data bytes and the padding.
    localparam int TOT_W       = $clog2(ALIGN_BYTES + 2);

    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    localparam int CFG_IDX_W   = 3;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FAN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STRIP  = 3'd4;

    typedef enum logic [1:0] {
        KIND_COPY  = 2'd0,
        KIND_INDEX = 2'd1,
        KIND_PAD   = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        PH_CMD    = 3'd0,
        PH_CNT_HI = 3'd1,
        PH_CNT_LO = 3'd2,
        PH_VERTEX = 3'd3,
        PH_DRAIN  = 3'd4
    } phase_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_payload_t;

    typedef struct packed {
        logic [7:0] out_byte;
        kind_t      out_kind;
        logic       out_run_last;
        logic       out_list_end;
    } out_payload_t;

    typedef struct packed {
        logic [7:0] vertex_stride;
        logic [7:0] insert_offset;
        logic [7:0] index_base;
        logic [7:0] fan_opcode;
        logic [7:0] strip_opcode;
    } cfg_t;

    // One classified request: up to two data bytes followed by padding zeros.
    typedef struct packed {
        logic [7:0]       d0_byte;
        kind_t            d0_kind;
        logic [7:0]       d1_byte;
        kind_t            d1_kind;
        logic [1:0]       n_data;
        logic [TOT_W-1:0] total;
        logic             list_end;
    } job_t;

    localparam logic [MOD_W:0] ALIGN_V = ALIGN_BYTES[MOD_W:0];

    // Byte count modulo the alignment after adding up to two bytes.
    function automatic logic [MOD_W-1:0] add_mod(input logic [MOD_W-1:0] c,
                                                 input logic [1:0] n);
        logic [MOD_W:0] s;
        begin
            s = {1'b0, c} + {{(MOD_W - 1){1'b0}}, n};
            if (s >= ALIGN_V)
            begin
                s = s - ALIGN_V;
            end
            if (s >= ALIGN_V)
            begin
                s = s - ALIGN_V;
            end
            add_mod = s[MOD_W-1:0];
        end
    endfunction

    // Number of zeros that bring the byte count to the next alignment boundary.
    function automatic logic [MOD_W-1:0] pad_len(input logic [MOD_W-1:0] c);
        logic [MOD_W:0] d;
        begin
            d = ALIGN_V - {1'b0, c};
            if (c == '0)
            begin
                pad_len = '0;
            end
            else
            begin
                pad_len = d[MOD_W-1:0];
            end
        end
    endfunction

endpackage

// File: rtl/dlii_front.sv
// ----------------------------------------------------------------------------
// dlii_front
// Parses the incoming display list and classifies each byte into a job.
// ----------------------------------------------------------------------------
module dlii_front import dlii_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  in_payload_t in_data,
    input  cfg_t        cfg,
    output logic        push,
    output job_t        job
);

    phase_t           phase_reg, phase_next;
    logic [7:0]       count_high_reg, count_high_next;
    logic [15:0]      vleft_reg, vleft_next;
    logic [7:0]       bpos_reg, bpos_next;
    logic [7:0]       first_reg, first_next;
    logic [MOD_W-1:0] mod_reg, mod_next;

    logic [7:0]       b;
    logic [7:0]       s_eff;
    logic [7:0]       a_eff;
    logic [7:0]       first_byte;
    logic [7:0]       idx_val;
    logic             last_of_vertex;
    logic [1:0]       n_data;
    logic [MOD_W-1:0] mod_after;
    logic [MOD_W-1:0] pad;
    logic [TOT_W-1:0] total;

    assign b          = in_data.in_byte;
    assign s_eff      = (cfg.vertex_stride == 8'd0) ? 8'd1 : cfg.vertex_stride;
    assign a_eff      = (cfg.insert_offset > s_eff) ? s_eff : cfg.insert_offset;
    assign first_byte = (bpos_reg == 8'd0) ? b : first_reg;
    assign idx_val    = cfg.index_base + first_byte;
    assign last_of_vertex = ({1'b0, bpos_reg} + 9'd1) >= {1'b0, s_eff};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_CMD;
            count_high_reg <= '0;
            vleft_reg      <= '0;
            bpos_reg       <= '0;
            first_reg      <= '0;
            mod_reg        <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            count_high_reg <= count_high_next;
            vleft_reg      <= vleft_next;
            bpos_reg       <= bpos_next;
            first_reg      <= first_next;
            mod_reg        <= mod_next;
        end
    end

    always_comb
    begin
        phase_next      = phase_reg;
        count_high_next = count_high_reg;
        vleft_next      = vleft_reg;
        bpos_next       = bpos_reg;
        first_next      = first_reg;
        mod_next        = mod_reg;
        n_data          = 2'd0;
        job             = '0;
        job.d0_byte     = b;
        job.d0_kind     = KIND_COPY;
        job.d1_kind     = KIND_COPY;
        mod_after       = mod_reg;
        pad             = '0;
        total           = '0;
        push            = 1'b0;

        if (accept)
        begin
            unique case (phase_reg)
                PH_CMD:
                begin
                    n_data = 2'd1;
                    if (b == cfg.fan_opcode || b == cfg.strip_opcode)
                    begin
                        phase_next = PH_CNT_HI;
                    end
                    else
                    begin
                        phase_next = PH_DRAIN;
                    end
                end
                PH_CNT_HI:
                begin
                    n_data          = 2'd1;
                    count_high_next = b;
                    phase_next      = PH_CNT_LO;
                end
                PH_CNT_LO:
                begin
                    n_data     = 2'd1;
                    vleft_next = {count_high_reg, b};
                    bpos_next  = '0;
                    phase_next = ({count_high_reg, b} != 16'd0) ? PH_VERTEX : PH_CMD;
                end
                PH_VERTEX:
                begin
                    first_next = first_byte;
                    if (bpos_reg == a_eff)
                    begin
                        // Index byte goes in front of this vertex byte.
                        n_data      = 2'd2;
                        job.d0_byte = idx_val;
                        job.d0_kind = KIND_INDEX;
                        job.d1_byte = b;
                    end
                    else if (last_of_vertex && (a_eff > bpos_reg))
                    begin
                        // Insert position lies at or past the vertex end.
                        n_data      = 2'd2;
                        job.d1_byte = idx_val;
                        job.d1_kind = KIND_INDEX;
                    end
                    else
                    begin
                        n_data = 2'd1;
                    end
                    if (last_of_vertex)
                    begin
                        bpos_next  = '0;
                        vleft_next = vleft_reg - 16'd1;
                        if (vleft_reg == 16'd1)
                        begin
                            phase_next = PH_CMD;
                        end
                    end
                    else
                    begin
                        bpos_next = bpos_reg + 8'd1;
                    end
                end
                PH_DRAIN:
                begin
                    n_data = 2'd0;
                end
                default:
                begin
                    phase_next = PH_CMD;
                end
            endcase

            mod_after = add_mod(mod_reg, n_data);
            if (in_data.in_last)
            begin
                pad             = pad_len(mod_after);
                phase_next      = PH_CMD;
                count_high_next = '0;
                vleft_next      = '0;
                bpos_next       = '0;
                first_next      = '0;
                mod_next        = '0;
            end
            else
            begin
                mod_next = mod_after;
            end

            total        = TOT_W'(n_data) + TOT_W'(pad);
            job.n_data   = n_data;
            job.total    = total;
            job.list_end = in_data.in_last;
            push         = (total != '0);
        end
    end

`ifndef SYNTHESIS
    a_mod_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, mod_reg} < ALIGN_V)
        else $error("byte count modulo alignment out of range");
`endif

endmodule

// File: rtl/dlii_queue.sv
// ----------------------------------------------------------------------------
// dlii_queue
// Short job queue between the parsing front and the output back end.
// ----------------------------------------------------------------------------
module dlii_queue import dlii_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic valid,
    output logic full,
    output job_t head
);

    job_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign valid   = (count_reg != '0);
    assign full    = (count_reg == QCNT_W'(QDEPTH));
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("job queue overfilled");
`endif

endmodule

// File: rtl/dlii_back.sv
// ----------------------------------------------------------------------------
// dlii_back
// Expands queued jobs into result bytes, one per clock while out_stall is low, into an output register.
// ----------------------------------------------------------------------------
module dlii_back import dlii_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_valid,
    input  job_t         q_head,
    output logic         pop,
    output logic         out_valid,
    input  logic         out_stall,
    output out_payload_t out_data
);

    logic             cur_valid_reg, cur_valid_next;
    job_t             cur_reg, cur_next;
    logic [TOT_W-1:0] idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;
    out_payload_t     out_reg, out_next;

    logic             advance;
    logic             final_res;
    logic             load;
    out_payload_t     res;

    assign advance   = !out_valid_reg || !out_stall;
    assign final_res = (idx_reg == (cur_reg.total - TOT_W'(1)));
    assign load      = !cur_valid_reg || (advance && final_res);
    assign pop       = load && q_valid;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        if (idx_reg == '0 && cur_reg.n_data != 2'd0)
        begin
            res.out_byte = cur_reg.d0_byte;
            res.out_kind = cur_reg.d0_kind;
        end
        else if (idx_reg < TOT_W'(cur_reg.n_data))
        begin
            res.out_byte = cur_reg.d1_byte;
            res.out_kind = cur_reg.d1_kind;
        end
        else
        begin
            res.out_byte = 8'd0;
            res.out_kind = KIND_PAD;
        end
        res.out_run_last = final_res;
        res.out_list_end = final_res && cur_reg.list_end;
    end

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cur_next       = cur_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (advance)
        begin
            out_valid_next = cur_valid_reg;
            if (cur_valid_reg)
            begin
                out_next = res;
                idx_next = idx_reg + TOT_W'(1);
            end
        end
        if (load)
        begin
            cur_valid_next = q_valid;
            cur_next       = q_head;
            idx_next       = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

`ifndef SYNTHESIS
    a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (idx_reg < cur_reg.total))
        else $error("result index ran past the end of the job");
`endif

endmodule

// File: rtl/display_list_index_inserter_top.sv
// ----------------------------------------------------------------------------
// display_list_index_inserter_top
// Display list rewriter that inserts an index byte into every vertex.
// ----------------------------------------------------------------------------
// The block takes the original display list one byte per request and returns
// the rewritten list one byte per request. A front end parses commands, vertex
// counts and vertices and turns each input byte into a job of up to two data
// bytes, plus the zero padding when in_last closes the list. A two-entry job
// queue decouples it from the back end, which drains jobs through a single
// output register at one result per clock while out_stall is low. An input
// byte therefore causes one result for a plain copy,
// two where an index byte is inserted, and up to 33 on the final byte when
// the padding is long. Sustained input rate is one byte per clock while each
// byte yields one result and the output is not stalled. A byte that follows a
// command other than the fan or strip opcode is discarded and yields nothing.
// An input byte passes the job queue, the current-job register and the output
// register before its first result appears. Configuration is written through
// a plain write port and must only change while the block is idle.
// ----------------------------------------------------------------------------
module display_list_index_inserter_top import dlii_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_payload_t          in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_payload_t         out_data
);

    // Configuration registers, reset to the standard opcodes and unit stride.
    cfg_t cfg_reg, cfg_next;

    logic in_accept;
    logic front_push;
    job_t front_job;
    logic q_valid;
    logic q_full;
    job_t q_head;
    logic back_pop;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_STRIDE: cfg_next.vertex_stride = cfg_data;
                REG_OFFSET: cfg_next.insert_offset = cfg_data;
                REG_BASE:   cfg_next.index_base    = cfg_data;
                REG_FAN:    cfg_next.fan_opcode    = cfg_data;
                REG_STRIP:  cfg_next.strip_opcode  = cfg_data;
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.vertex_stride <= 8'd1;
            cfg_reg.insert_offset <= 8'd0;
            cfg_reg.index_base    <= 8'd0;
            cfg_reg.fan_opcode    <= 8'hA0;
            cfg_reg.strip_opcode  <= 8'h98;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // The front end stalls only on a full job queue, so stall never looks at
    // the incoming valid.
    assign in_stall  = q_full;
    assign in_accept = in_valid && !q_full;

    dlii_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (in_accept),
        .in_data (in_data),
        .cfg     (cfg_reg),
        .push    (front_push),
        .job     (front_job)
    );

    dlii_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (front_push),
        .push_job (front_job),
        .pop      (back_pop),
        .valid    (q_valid),
        .full     (q_full),
        .head     (q_head)
    );

    dlii_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .pop       (back_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

`ifndef SYNTHESIS
    a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.out_list_end) |-> out_data.out_run_last)
        else $error("list end flagged on a result that is not the last of its request");
`endif

endmodule
